// File: rtl/core/dnff_pkg.sv
// Package for the dead-nonce FIFO filter: widths, opcodes, register indexes,
// reset values and the limit clamp. No dependencies.
`default_nettype none

package dnff_pkg;

    localparam int DEPTH      = 1024;
    localparam int PTR_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int HALF_W     = 32;
    localparam int KEY_W      = 2 * HALF_W;
    localparam int OP_W       = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = CNT_W;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_LIMIT = 2'd1;

    localparam logic [CNT_W-1:0] EXPECTED_RST   = CNT_W'(6);
    localparam logic [CNT_W-1:0] INIT_LIMIT_RST = CNT_W'(256);

    // floor(x/5) = (x*RECIP) >> 18 and floor(x/10) = (x*RECIP) >> 19, exact for x < 2^16
    localparam int               MUL_IN_W     = CNT_W + 4;
    localparam int               RECIP_W      = 16;
    localparam logic [RECIP_W-1:0] RECIP      = 16'hCCCD;
    localparam int               GROW_SHIFT   = 18;
    localparam int               SHRINK_SHIFT = 19;
    localparam int               GROW_MUL     = 6;
    localparam int               SHRINK_MUL   = 9;

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef struct packed {
        logic             mark;
        logic [KEY_W-1:0] key;
    } entry_t;

    function automatic cnt_t clamp_limit(input cnt_t v);
        if (v == '0) begin
            return cnt_t'(1);
        end
        if (v > cnt_t'(DEPTH)) begin
            return cnt_t'(DEPTH);
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/dead_nonce_fifo_filter_core.sv
// Dead-nonce FIFO filter: circular key store with marks, lookup scan,
// adaptive size limit. Depends on dnff_pkg.
//
// Insert writes the key, then evicts the oldest entries while over the limit (one
// eviction first when full); tick adjusts the limit, then does the same with a mark.
// Lookup scans every stored entry. One item at a time; evictions and the lookup scan
// use the single store read port, one entry per cycle. A result waits while stalled.
// Reset clears pointers and counts, loads limit 256 and expected marks 6;
// the key store is not cleared.
`default_nettype none

module dead_nonce_fifo_filter_core import dnff_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [OP_W-1:0]       s_opcode,
    input  wire logic [HALF_W-1:0]     s_name_hash,
    input  wire logic [HALF_W-1:0]     s_nonce,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_found,
    output logic [CNT_W-1:0]           m_occupancy,
    output logic [CNT_W-1:0]           m_current_limit
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_ADJ    = 3'd1;
    localparam logic [2:0] ST_PREPOP = 3'd2;
    localparam logic [2:0] ST_WRITE  = 3'd3;
    localparam logic [2:0] ST_EVICT  = 3'd4;
    localparam logic [2:0] ST_SCAN   = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic [OP_W-1:0]  op_reg;
    logic [KEY_W-1:0] key_reg;
    ptr_t             head_reg, head_next;
    cnt_t             count_reg, count_next;
    cnt_t             marks_reg, marks_next;
    cnt_t             limit_reg, limit_next;
    cnt_t             expected_reg, expected_next;
    ptr_t             scan_ptr_reg, scan_ptr_next;
    cnt_t             scan_left_reg, scan_left_next;
    logic             cmp_vld_reg, cmp_vld_next;
    logic             hit_reg, hit_next;
    logic             m_valid_reg, m_valid_next;
    logic             found_reg, found_next;
    cnt_t             occ_reg, occ_next;
    cnt_t             lim_out_reg, lim_out_next;

    entry_t           mem [DEPTH];
    entry_t           rd_data_reg;
    ptr_t             rd_addr;
    logic             wr_en;
    ptr_t             wr_addr;
    entry_t           wr_data;
    logic             pop;
    logic             accept;
    logic             full;

    logic                        grow, shrink;
    logic [MUL_IN_W-1:0]         mul_in;
    logic [MUL_IN_W+RECIP_W-1:0] mul_out;
    cnt_t                        quot;
    cnt_t                        adj_limit;

    function automatic ptr_t ptr_wrap(input ptr_t base, input cnt_t offs);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(offs);
        if (sum >= (CNT_W + 1)'(DEPTH)) begin
            sum = sum - (CNT_W + 1)'(DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

    assign s_ready         = (state_reg == ST_IDLE);
    assign accept          = s_valid && s_ready;
    assign full            = (count_reg == cnt_t'(DEPTH));
    assign m_valid         = m_valid_reg;
    assign m_found         = found_reg;
    assign m_occupancy     = occ_reg;
    assign m_current_limit = lim_out_reg;

    assign grow    = (expected_reg > marks_reg);
    assign shrink  = (expected_reg < marks_reg);
    assign mul_in  = grow ? MUL_IN_W'(limit_reg) * MUL_IN_W'(GROW_MUL)
                          : MUL_IN_W'(limit_reg) * MUL_IN_W'(SHRINK_MUL);
    assign mul_out = (MUL_IN_W + RECIP_W)'(mul_in) * (MUL_IN_W + RECIP_W)'(RECIP);
    assign quot    = grow ? mul_out[GROW_SHIFT +: CNT_W] : mul_out[SHRINK_SHIFT +: CNT_W];
    assign adj_limit = (grow || shrink) ? clamp_limit(quot) : limit_reg;

    always_comb begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        marks_next     = marks_reg;
        limit_next     = limit_reg;
        expected_next  = expected_reg;
        scan_ptr_next  = scan_ptr_reg;
        scan_left_next = scan_left_reg;
        cmp_vld_next   = cmp_vld_reg;
        hit_next       = hit_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        found_next     = found_reg;
        occ_next       = occ_reg;
        lim_out_next   = lim_out_reg;
        rd_addr        = head_reg;
        wr_en          = 1'b0;
        wr_addr        = ptr_wrap(head_reg, count_reg);
        wr_data.mark   = (op_reg == OP_TICK);
        wr_data.key    = key_reg;
        pop            = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    hit_next = 1'b0;
                    unique case (s_opcode)
                        OP_INSERT: state_next = full ? ST_PREPOP : ST_WRITE;
                        OP_LOOKUP: begin
                            scan_ptr_next  = head_reg;
                            scan_left_next = count_reg;
                            cmp_vld_next   = 1'b0;
                            state_next     = ST_SCAN;
                        end
                        OP_TICK:   state_next = ST_ADJ;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_ADJ: begin
                limit_next = adj_limit;
                state_next = full ? ST_PREPOP : ST_WRITE;
            end
            ST_PREPOP: begin
                pop        = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                wr_en      = 1'b1;
                count_next = count_reg + cnt_t'(1);
                if (op_reg == OP_TICK) begin
                    marks_next = marks_reg + cnt_t'(1);
                end
                state_next = ST_EVICT;
            end
            ST_EVICT: begin
                if (count_reg > limit_reg) begin
                    pop = 1'b1;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_SCAN: begin
                if (cmp_vld_reg && !rd_data_reg.mark && (rd_data_reg.key == key_reg)) begin
                    hit_next = 1'b1;
                end
                if (scan_left_reg != '0) begin
                    rd_addr        = scan_ptr_reg;
                    scan_ptr_next  = ptr_wrap(scan_ptr_reg, cnt_t'(1));
                    scan_left_next = scan_left_reg - cnt_t'(1);
                    cmp_vld_next   = 1'b1;
                end else begin
                    cmp_vld_next = 1'b0;
                    if (!cmp_vld_reg) begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    found_next   = hit_reg;
                    occ_next     = count_reg;
                    lim_out_next = limit_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // drop the oldest entry; read data holds the head entry
        if (pop) begin
            head_next  = ptr_wrap(head_reg, cnt_t'(1));
            rd_addr    = head_next;
            count_next = count_reg - cnt_t'(1);
            if (rd_data_reg.mark && (marks_reg != '0)) begin
                marks_next = marks_reg - cnt_t'(1);
            end
        end

        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_EXPECTED:   expected_next = cfg_data;
                CFG_INIT_LIMIT: limit_next    = clamp_limit(cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            marks_reg     <= '0;
            limit_reg     <= clamp_limit(INIT_LIMIT_RST);
            expected_reg  <= EXPECTED_RST;
            scan_ptr_reg  <= '0;
            scan_left_reg <= '0;
            cmp_vld_reg   <= 1'b0;
            hit_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            marks_reg     <= marks_next;
            limit_reg     <= limit_next;
            expected_reg  <= expected_next;
            scan_ptr_reg  <= scan_ptr_next;
            scan_left_reg <= scan_left_next;
            cmp_vld_reg   <= cmp_vld_next;
            hit_reg       <= hit_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        found_reg   <= found_next;
        occ_reg     <= occ_next;
        lim_out_reg <= lim_out_next;
        if (accept) begin
            op_reg  <= s_opcode;
            key_reg <= {s_name_hash, s_nonce};
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// File: rtl/core/dnff_checker.sv
// Port-level checks for dead_nonce_fifo_filter_core, attached by bind.
// Depends on dnff_pkg.
`default_nettype none

module dnff_checker import dnff_pkg::*; (
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  cfg_wr_en,
    input wire logic [CFG_IDX_W-1:0]  cfg_index,
    input wire logic [CFG_DATA_W-1:0] cfg_data,
    input wire logic                  s_valid,
    input wire logic                  s_ready,
    input wire logic [OP_W-1:0]       s_opcode,
    input wire logic [HALF_W-1:0]     s_name_hash,
    input wire logic [HALF_W-1:0]     s_nonce,
    input wire logic                  m_valid,
    input wire logic                  m_ready,
    input wire logic                  m_found,
    input wire logic [CNT_W-1:0]      m_occupancy,
    input wire logic [CNT_W-1:0]      m_current_limit
);

    a_busy_after_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input ready right after a transfer");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_found) && $stable(m_occupancy)
                                   && $stable(m_current_limit)))
        else $error("stalled result changed");

    a_limit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_current_limit != '0) && (m_current_limit <= CNT_W'(DEPTH))
                     && (m_occupancy <= CNT_W'(DEPTH))))
        else $error("limit or occupancy out of range");

    a_found_needs_entries: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_found) |-> (m_occupancy != '0))
        else $error("hit reported on empty store");

endmodule

bind dead_nonce_fifo_filter_core dnff_checker u_dnff_checker (.*);

`default_nettype wire
